FILE: src/jpeg_quality_quantizer_unit_assert.svh
// Assertion macros for the quantiser checker.
`ifndef JPEG_QUALITY_QUANTIZER_UNIT_ASSERT_SVH
`define JPEG_QUALITY_QUANTIZER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define JQQ_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("quantiser assertion failed");

// Clocked assertion that is checked during reset as well.
`define JQQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("quantiser assertion failed");

`endif

FILE: src/jqq_pkg.sv
// Constants, base tables and widths for the JPEG quality quantiser.
package jqq_pkg;

    localparam int COEF_W   = 16;
    localparam int POS_W    = 6;
    localparam int QUALITY_W = 7;
    localparam int SCALE_W  = 13;
    localparam int BASE_W   = 7;
    localparam int PROD_W   = 20;
    localparam int DQ_W     = 14;
    localparam int DIV_W    = 8;
    localparam int RECIP_W  = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STAGES   = 6;
    localparam int DIVISOR_STAGES = 4;

    localparam int unsigned SCALE_NUM = 5000;
    localparam int unsigned SCALE_MID = 50;
    localparam int unsigned SCALE_TOP = 200;
    localparam int unsigned QUALITY_MAX = 100;
    localparam int unsigned DIV_MAX = 255;

    localparam logic [QUALITY_W-1:0] QUALITY_RESET = 7'd50;
    localparam logic [SCALE_W-1:0]   SCALE_RESET   = 13'd100;
    localparam logic [PROD_W-1:0]    ROUND_HALF    = 20'd50;

    // Multiplying by DIV100_MUL and shifting by DIV100_SHIFT divides by 100
    // exactly for every product this block can form.
    localparam logic [20:0] DIV100_MUL   = 21'd1342178;
    localparam int          DIV100_SHIFT = 27;

    localparam logic [0:0] REG_QUALITY = 1'b0;

    localparam logic [BASE_W-1:0] LUMA_BASE [64] = '{
        7'd16,  7'd11,  7'd10,  7'd16,  7'd24,  7'd40,  7'd51,  7'd61,
        7'd12,  7'd12,  7'd14,  7'd19,  7'd26,  7'd58,  7'd60,  7'd55,
        7'd14,  7'd13,  7'd16,  7'd24,  7'd40,  7'd57,  7'd69,  7'd56,
        7'd14,  7'd17,  7'd22,  7'd29,  7'd51,  7'd87,  7'd80,  7'd62,
        7'd18,  7'd22,  7'd37,  7'd56,  7'd68,  7'd109, 7'd103, 7'd77,
        7'd24,  7'd35,  7'd55,  7'd64,  7'd81,  7'd104, 7'd113, 7'd92,
        7'd49,  7'd64,  7'd78,  7'd87,  7'd103, 7'd121, 7'd120, 7'd101,
        7'd72,  7'd92,  7'd95,  7'd98,  7'd112, 7'd100, 7'd103, 7'd99
    };

    localparam logic [BASE_W-1:0] CHROMA_BASE [64] = '{
        7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
    };

endpackage

FILE: src/jqq_cfg.sv
// Configuration port: quality register and the scale factor derived from it.
module jqq_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [jqq_pkg::ADDR_W-1:0]     paddr,
    input  logic [jqq_pkg::DATA_W-1:0]     pwdata,
    output logic [jqq_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    output logic [jqq_pkg::SCALE_W-1:0]    o_scale
);

    logic [jqq_pkg::QUALITY_W-1:0] r_quality;
    logic [jqq_pkg::SCALE_W-1:0]   r_scale;
    logic [jqq_pkg::SCALE_W-1:0]   w_scale_tab [128];
    logic                          w_wr;

    // Scale for every possible register value, worked out at elaboration.
    for (genvar Gq = 0; Gq < 128; Gq++) begin : g_scale
        localparam int unsigned Qe = (Gq == 0) ? 1 :
            ((Gq > jqq_pkg::QUALITY_MAX) ? jqq_pkg::QUALITY_MAX : Gq);
        localparam int unsigned Sc = (Qe < jqq_pkg::SCALE_MID) ?
            (jqq_pkg::SCALE_NUM / Qe) : (jqq_pkg::SCALE_TOP - 2 * Qe);
        assign w_scale_tab[Gq] = jqq_pkg::SCALE_W'(Sc);
    end

    assign w_wr  = psel && penable && pwrite && (paddr[2] == jqq_pkg::REG_QUALITY);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quality <= jqq_pkg::QUALITY_RESET;
            r_scale   <= jqq_pkg::SCALE_RESET;
        end else if (w_wr) begin
            r_quality <= pwdata[jqq_pkg::QUALITY_W-1:0];
            r_scale   <= w_scale_tab[pwdata[jqq_pkg::QUALITY_W-1:0]];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == jqq_pkg::REG_QUALITY) begin
            prdata = {{(jqq_pkg::DATA_W-jqq_pkg::QUALITY_W){1'b0}}, r_quality};
        end
    end

    assign o_scale = r_scale;

endmodule

FILE: src/jqq_divisor.sv
// Four-stage divisor pipeline: base lookup, scaling, divide by 100, clamp and reciprocal.
module jqq_divisor (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_sel,
    input  logic [jqq_pkg::POS_W-1:0]     i_pos,
    input  logic [jqq_pkg::SCALE_W-1:0]   i_scale,
    output logic [jqq_pkg::RECIP_W-1:0]   o_recip
);

    logic [jqq_pkg::BASE_W-1:0]  r_base;
    logic [jqq_pkg::PROD_W-1:0]  r_prod;
    logic [jqq_pkg::DQ_W-1:0]    r_dq;
    logic [jqq_pkg::RECIP_W-1:0] r_recip;
    logic [jqq_pkg::RECIP_W-1:0] w_recip_tab [256];
    logic [40:0]                 w_mul;
    logic [jqq_pkg::DIV_W-1:0]   w_div;

    // ceil(2^24 / d): exact floor division for magnitudes up to 32768.
    for (genvar Gd = 0; Gd < 256; Gd++) begin : g_recip
        localparam int unsigned Dv = (Gd == 0) ? 1 : Gd;
        assign w_recip_tab[Gd] =
            jqq_pkg::RECIP_W'((32'd16777216 + 32'(Dv) - 32'd1) / 32'(Dv));
    end

    assign w_mul = 41'(r_prod) * 41'(jqq_pkg::DIV100_MUL);

    always_comb begin
        if (r_dq == '0) begin
            w_div = 8'd1;
        end else if (r_dq > jqq_pkg::DQ_W'(jqq_pkg::DIV_MAX)) begin
            w_div = jqq_pkg::DIV_W'(jqq_pkg::DIV_MAX);
        end else begin
            w_div = r_dq[jqq_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base  <= i_sel ? jqq_pkg::CHROMA_BASE[i_pos] : jqq_pkg::LUMA_BASE[i_pos];
            r_prod  <= jqq_pkg::PROD_W'(r_base) * jqq_pkg::PROD_W'(i_scale)
                       + jqq_pkg::ROUND_HALF;
            r_dq    <= w_mul[jqq_pkg::DIV100_SHIFT +: jqq_pkg::DQ_W];
            r_recip <= w_recip_tab[w_div];
        end
    end

    assign o_recip = r_recip;

endmodule

FILE: src/jqq_divide.sv
// Two-stage divide by reciprocal multiplication with truncation toward zero.
module jqq_divide (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [jqq_pkg::COEF_W-1:0]  i_coef,
    input  logic [jqq_pkg::RECIP_W-1:0]        i_recip,
    output logic [jqq_pkg::COEF_W-1:0]         o_quant
);

    localparam int PW = jqq_pkg::COEF_W + 1 + jqq_pkg::RECIP_W;

    logic                         r_neg;
    logic [PW-1:0]                r_prod;
    logic [jqq_pkg::COEF_W-1:0]   r_quant;
    logic [jqq_pkg::COEF_W:0]     w_mag;
    logic [jqq_pkg::COEF_W:0]     w_q;

    assign w_mag = i_coef[jqq_pkg::COEF_W-1] ?
                   (17'd0 - {1'b1, i_coef}) : {1'b0, i_coef};
    assign w_q   = r_prod[jqq_pkg::RECIP_SHIFT +: jqq_pkg::COEF_W + 1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg   <= i_coef[jqq_pkg::COEF_W-1];
            r_prod  <= PW'(w_mag) * PW'(i_recip);
            r_quant <= r_neg ? jqq_pkg::COEF_W'(17'd0 - w_q) : w_q[jqq_pkg::COEF_W-1:0];
        end
    end

    assign o_quant = r_quant;

endmodule

FILE: src/jpeg_quality_quantizer_unit.sv
// Six-stage quantiser: the four divisor stages followed by the two divide stages.
// Throughput is one item per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stall holds every stage in place.
// The slowest stage is the 17 by 25 bit multiply by the reciprocal of the divisor.
// Synchronous active-low reset empties the pipeline and sets quality to 50.
module jpeg_quality_quantizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] coefficient, [21:16] position, [23:22] zero
    input  logic        s_tuser,   // [0] table_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] quantized
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [jqq_pkg::STAGES-1:0]     r_vld;
    logic [jqq_pkg::COEF_W-1:0]     r_coef_dly [jqq_pkg::DIVISOR_STAGES];
    logic                           w_en;
    logic [jqq_pkg::SCALE_W-1:0]    w_scale;
    logic [jqq_pkg::RECIP_W-1:0]    w_recip;

    assign w_en     = !r_vld[jqq_pkg::STAGES-1] || m_tready;
    assign s_tready = w_en;
    assign m_tvalid = r_vld[jqq_pkg::STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[jqq_pkg::STAGES-2:0], s_tvalid};
        end
    end

    // The coefficient waits alongside the divisor pipeline.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_coef_dly[0] <= s_tdata[jqq_pkg::COEF_W-1:0];
            for (int i = 1; i < jqq_pkg::DIVISOR_STAGES; i++) begin
                r_coef_dly[i] <= r_coef_dly[i-1];
            end
        end
    end

    jqq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_scale (w_scale)
    );

    jqq_divisor u_divisor (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_sel   (s_tuser),
        .i_pos   (s_tdata[16 +: jqq_pkg::POS_W]),
        .i_scale (w_scale),
        .o_recip (w_recip)
    );

    jqq_divide u_divide (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_coef  (r_coef_dly[jqq_pkg::DIVISOR_STAGES-1]),
        .i_recip (w_recip),
        .o_quant (m_tdata)
    );

endmodule

FILE: src/jqq_checker.sv
// Port-level checker for the quantiser and its bind to the top level.
`include "jpeg_quality_quantizer_unit_assert.svh"

module jqq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    logic w_quality_wr;

    assign w_quality_wr = psel && penable && pwrite && pready && !paddr[2];

    `JQQ_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `JQQ_ASSERT(a_ready_when_free, !m_tvalid || m_tready |-> s_tready)
    `JQQ_ASSERT(a_quality_readback, w_quality_wr |=> paddr[2] || prdata[6:0] == $past(pwdata[6:0]))
    `JQQ_ASSERT_ALWAYS(a_pready_high, pready)

endmodule

bind jpeg_quality_quantizer_unit jqq_checker u_jqq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

FILE: verif/jpeg_quality_quantizer_unit_tb.sv
// Self-checking testbench for the JPEG quality quantiser stream block.
module jpeg_quality_quantizer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] coefficient, [21:16] position, [23:22] zero
    logic        s_tuser;   // [0] table_select
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] quantized
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typedef struct packed {
        logic signed [15:0] coef;
        logic               chroma;
        logic [5:0]         pos;
    } t_coef_item;

    t_coef_item        pending_items[$];
    logic signed [15:0] expected_quant[$];
    logic [6:0]        quality_setting;
    int                error_count;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                hold_cycles;

    jpeg_quality_quantizer_unit DUT (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int divisor_of(logic [6:0] quality, logic chroma, logic [5:0] pos);
        int q;
        int pct;
        int base;
        int d;
        q = quality;
        if (q == 0) q = 1;
        if (q > 100) q = 100;
        pct = (q < 50) ? 5000 / q : 200 - 2 * q;
        base = chroma ? jqq_pkg::CHROMA_BASE[pos] : jqq_pkg::LUMA_BASE[pos];
        d = (base * pct + 50) / 100;
        if (d < 1) d = 1;
        if (d > 255) d = 255;
        return d;
    endfunction

    function automatic logic signed [15:0] quantise(t_coef_item it);
        int c;
        c = it.coef;
        // SystemVerilog integer division truncates toward zero.
        return 16'(c / divisor_of(quality_setting, it.chroma, it.pos));
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Driver: expectations are pushed at the accepting edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_quant.push_back(quantise(t_coef_item'({s_tdata[15:0], s_tuser,
                                                                s_tdata[21:16]})));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_coef_item it;
                    it = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, it.pos, it.coef};
                    s_tuser  <= it.chroma;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_quant.size() == 0) begin
                report_mismatch($sformatf("unexpected item %0d", $signed(m_tdata)));
            end else begin
                logic signed [15:0] want;
                want = expected_quant.pop_front();
                if (m_tdata !== want)
                    report_mismatch($sformatf("quantized %0d, expected %0d",
                                              $signed(m_tdata), want));
            end
        end
    end

    task automatic write_quality(logic [6:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'({jqq_pkg::REG_QUALITY, 2'b00}); pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        quality_setting = value;
    endtask

    task automatic drain;
        while (pending_items.size() > 0 || s_tvalid || expected_quant.size() > 0)
            @(posedge i_clk);
        repeat (jqq_pkg::STAGES + 4) @(posedge i_clk);
    endtask

    task automatic add_random(int n);
        t_coef_item it;
        repeat (n) begin
            it.coef = 16'($urandom);
            if ($urandom_range(9) == 0) it.coef = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
            else if ($urandom_range(3) == 0) it.coef = 16'($signed($urandom_range(600)) - 300);
            it.chroma = 1'($urandom);
            it.pos = 6'($urandom);
            pending_items.push_back(it);
        end
    endtask

    initial begin
        t_coef_item it;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0; send_idle_pct = 12; recv_idle_pct = 85; hold_cycles = 0;
        quality_setting = jqq_pkg::QUALITY_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset quality: extremes and both tables.
        for (int k = 0; k < 16; k++) begin
            it.coef = (k % 4 == 0) ? 16'sh8000 : (k % 4 == 1) ? 16'sh7fff :
                      (k % 4 == 2) ? 16'sh0000 : 16'shffff;
            it.chroma = k[0] ^ k[2];
            it.pos = (k < 8) ? 6'd0 : 6'd63;
            pending_items.push_back(it);
        end
        drain();

        // Quality zero, above one hundred (most negative coefficient with divisor 1).
        write_quality(7'd0);
        it = '{16'sh8000, 1'b0, 6'd0};  pending_items.push_back(it);
        it = '{16'sh7fff, 1'b1, 6'd63}; pending_items.push_back(it);
        drain();
        write_quality(7'd127);
        it = '{16'sh8000, 1'b1, 6'd5};  pending_items.push_back(it);
        it = '{16'sh7fff, 1'b0, 6'd42}; pending_items.push_back(it);
        drain();

        // Long receiver hold-off while the sender keeps offering items.
        write_quality(7'd1);
        hold_cycles = 60;
        add_random(40);
        drain();

        send_idle_pct = 12; recv_idle_pct = 85;
        write_quality(7'd100); add_random(100); drain();
        write_quality(7'd49);  add_random(100); drain();
        send_idle_pct = 85; recv_idle_pct = 12;
        write_quality(7'd50);  add_random(100); drain();
        write_quality(7'd101); add_random(60);  drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        write_quality(7'($urandom_range(127))); add_random(150); drain();
        write_quality(7'd75);  add_random(150); drain();

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/jqq_pkg.sv
src/jqq_cfg.sv
src/jqq_divisor.sv
src/jqq_divide.sv
src/jpeg_quality_quantizer_unit.sv
src/jqq_checker.sv
verif/jpeg_quality_quantizer_unit_tb.sv
